[rtl/ffdl_pkg.sv]
`timescale 1ns / 1ps

package ffdl_pkg;

    // default sizes
    localparam int LINE_DEPTH_DEF  = 65536;
    localparam int SAMPLE_BITS_DEF = 24;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 22;

    // arithmetic limits
    localparam int FLUSH_LIMIT  = 8;
    localparam int FEEDBACK_MAX = 32765;

    // register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_USE_INPUT_DELAY    = 3'd0,
        REG_USE_INPUT_FEEDBACK = 3'd1,
        REG_FIXED_DELAY_MS     = 3'd2,
        REG_FIXED_FEEDBACK     = 3'd3,
        REG_SAMPLES_PER_MS     = 3'd4,
        REG_LINE_LENGTH        = 3'd5
    } ffdl_reg_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic load;
        logic scale;
        logic clamp;
        logic rd1;
        logic rd2;
        logic mix;
        logic fb;
        logic finish;
    } ffdl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic d_zero;
        logic out_busy;
    } ffdl_stat_t;

endpackage

[rtl/ffdl_if.sv]
`timescale 1ns / 1ps

// request channel: one audio sample with its delay and gain
interface ffdl_req_if #(
    parameter int SAMPLE_BITS = ffdl_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic signed [22:0]            delay_ms;
    logic signed [15:0]            feedback_gain;

    modport source (output valid, output sample_in, output delay_ms,
                    output feedback_gain, input ready);
    modport sink (input valid, input sample_in, input delay_ms,
                  input feedback_gain, output ready);
endinterface

// response channel: one delayed sample
interface ffdl_rsp_if #(
    parameter int SAMPLE_BITS = ffdl_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

[rtl/ffdl_ram.sv]
`timescale 1ns / 1ps

module ffdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ffdl_ctrl.sv]
`timescale 1ns / 1ps

module ffdl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ffdl_pkg::ffdl_stat_t stat,
    output ffdl_pkg::ffdl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCALE,
        S_CLAMP,
        S_RD1,
        S_RD2,
        S_MIX,
        S_FB,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                // zero integer delay skips the ring entirely
                cmd.rd1    = !stat.d_zero;
                state_next = stat.d_zero ? S_DONE : S_RD2;
            end
            S_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_FB;
            end
            S_FB:
            begin
                cmd.fb     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                cmd.finish = !stat.out_busy;
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !stat.out_busy)
        else $error("result finished while output register is occupied");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");
`endif

endmodule

[rtl/ffdl_dp.sv]
`timescale 1ns / 1ps

module ffdl_dp #(
    parameter int LINE_DEPTH  = ffdl_pkg::LINE_DEPTH_DEF,
    parameter int SAMPLE_BITS = ffdl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [ffdl_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [ffdl_pkg::CFG_DATA_BITS-1:0]  wr_data,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic signed [22:0]                  delay_ms,
    input  logic signed [15:0]                  feedback_gain,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [SAMPLE_BITS-1:0]       out_data,
    input  ffdl_pkg::ffdl_cmd_t                 cmd,
    output ffdl_pkg::ffdl_stat_t                stat
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int LW = AW + 1;
    localparam int CW = (LW > 17) ? LW : 17;
    localparam int DW = (LW > 22) ? LW : 22;
    localparam int SB = SAMPLE_BITS;
    localparam int AB = SB + 11;
    localparam int PW = SB + 17;
    localparam int SW = SB + 2;

    localparam logic signed [SW-1:0] SAT_HI = {3'b000, {(SB-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {3'b111, {(SB-1){1'b0}}};
    localparam logic signed [SW-1:0] FLUSH_HI = SW'(ffdl_pkg::FLUSH_LIMIT);
    localparam logic signed [SW-1:0] FLUSH_LO = -SW'(ffdl_pkg::FLUSH_LIMIT);

    // configuration registers
    logic        use_in_delay_reg;
    logic        use_in_fb_reg;
    logic [21:0] fixed_delay_reg;
    logic [14:0] fixed_fb_reg;
    logic [15:0] spm_reg;
    logic [16:0] len_cfg_reg;

    // control state
    logic [AW-1:0] wpos_reg;
    logic [AW-1:0] clear_cnt_reg;
    logic          out_valid_reg;

    // item payload
    logic signed [SB-1:0] x_reg;
    logic [21:0]          dq_reg;
    logic signed [15:0]   gain_reg;
    logic [LW-1:0]        len_reg;
    logic [21:0]          d_raw_reg;
    logic [7:0]           frac_reg;
    logic [LW-1:0]        d_reg;
    logic                 d_zero_reg;
    logic [AW-1:0]        r1_reg;
    logic signed [SB-1:0] s1_reg;
    logic signed [SB-1:0] y_reg;
    logic signed [SB:0]   fb_reg;
    logic signed [SB-1:0] out_data_reg;

    // ring ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [SB-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [SB-1:0] ram_rdata;

    ffdl_ram #(
        .WIDTH (SB),
        .DEPTH (LINE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // selection at load
    logic [CW-1:0]      len_wide;
    logic [LW-1:0]      len_sel;
    logic [21:0]        dq_sel;
    logic [14:0]        fixed_fb_sat;
    logic signed [15:0] gain_sel;

    always_comb
    begin
        len_wide = CW'(len_cfg_reg);
        if (len_wide < CW'(2))
        begin
            len_sel = LW'(2);
        end
        else if (len_wide > CW'(LINE_DEPTH))
        begin
            len_sel = LW'(LINE_DEPTH);
        end
        else
        begin
            len_sel = len_wide[LW-1:0];
        end
        if (use_in_delay_reg)
        begin
            dq_sel = delay_ms[22] ? 22'd0 : delay_ms[21:0];
        end
        else
        begin
            dq_sel = fixed_delay_reg;
        end
        fixed_fb_sat = (fixed_fb_reg > 15'(ffdl_pkg::FEEDBACK_MAX)) ?
                       15'(ffdl_pkg::FEEDBACK_MAX) : fixed_fb_reg;
        gain_sel = use_in_fb_reg ? feedback_gain : $signed({1'b0, fixed_fb_sat});
    end

    // delay scaling
    logic [37:0] prod;
    assign prod = 38'(dq_reg) * 38'(spm_reg);

    // clamp and ring addresses
    logic [LW-1:0] lm1;
    logic [LW-1:0] wz;
    logic [LW-1:0] r1;
    logic [AW-1:0] r2;
    logic [LW-1:0] wn;

    always_comb
    begin
        lm1 = len_reg - LW'(1);
        wz  = {1'b0, wpos_reg};
        r1  = (wz >= d_reg) ? (wz - d_reg) : (wz + len_reg - d_reg);
        r2  = (r1_reg == '0) ? lm1[AW-1:0] : (r1_reg - AW'(1));
        wn  = wz + LW'(1);
    end

    // interpolation
    logic [8:0]           w_hi;
    logic signed [AB-1:0] acc;
    logic signed [AB-1:0] acc_sh;

    always_comb
    begin
        w_hi   = 9'd256 - {1'b0, frac_reg};
        acc    = AB'(s1_reg) * AB'($signed({1'b0, w_hi}))
               + AB'($signed(ram_rdata)) * AB'($signed({1'b0, frac_reg}));
        acc_sh = (acc + AB'(128)) >>> 8;
    end

    // feedback product
    logic signed [PW-1:0] fbp;
    logic signed [PW-1:0] fbp_sh;

    always_comb
    begin
        fbp    = PW'(y_reg) * PW'(gain_reg);
        fbp_sh = (fbp + PW'(16384)) >>> 15;
    end

    // saturate and flush the value fed back
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sat;
    logic signed [SB-1:0] feed;

    always_comb
    begin
        sum = SW'(x_reg) + SW'(fb_reg);
        if (sum > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (sum < SAT_LO)
        begin
            sat = SAT_LO;
        end
        else
        begin
            sat = sum;
        end
        if ((sat <= FLUSH_HI) && (sat >= FLUSH_LO))
        begin
            feed = '0;
        end
        else
        begin
            feed = sat[SB-1:0];
        end
    end

    // ring port muxing
    always_comb
    begin
        ram_we    = cmd.clear | (cmd.finish & !d_zero_reg);
        ram_waddr = cmd.clear ? clear_cnt_reg : wpos_reg;
        ram_wdata = cmd.clear ? '0 : feed;
        ram_re    = cmd.rd1 | cmd.rd2;
        ram_raddr = cmd.rd1 ? r1[AW-1:0] : r2;
    end

    // config, write position, clear sweep and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_in_delay_reg <= 1'b0;
            use_in_fb_reg    <= 1'b0;
            fixed_delay_reg  <= 22'd25600;
            fixed_fb_reg     <= 15'd9830;
            spm_reg          <= 16'd11290;
            len_cfg_reg      <= 17'd44101;
            wpos_reg         <= '0;
            clear_cnt_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    ffdl_pkg::REG_USE_INPUT_DELAY:    use_in_delay_reg <= wr_data[0];
                    ffdl_pkg::REG_USE_INPUT_FEEDBACK: use_in_fb_reg    <= wr_data[0];
                    ffdl_pkg::REG_FIXED_DELAY_MS:     fixed_delay_reg  <= wr_data[21:0];
                    ffdl_pkg::REG_FIXED_FEEDBACK:     fixed_fb_reg     <= wr_data[14:0];
                    ffdl_pkg::REG_SAMPLES_PER_MS:     spm_reg          <= wr_data[15:0];
                    ffdl_pkg::REG_LINE_LENGTH:        len_cfg_reg      <= wr_data[16:0];
                    default:                          ;
                endcase
            end
            if (cmd.clear)
            begin
                clear_cnt_reg <= clear_cnt_reg + AW'(1);
            end
            if (cmd.load && ({1'b0, wpos_reg} >= len_sel))
            begin
                wpos_reg <= '0;
            end
            else if (cmd.finish)
            begin
                wpos_reg <= (wn >= len_reg) ? '0 : wn[AW-1:0];
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= sample_in;
            dq_reg   <= dq_sel;
            gain_reg <= gain_sel;
            len_reg  <= len_sel;
        end
        if (cmd.scale)
        begin
            d_raw_reg <= prod[37:16];
            frac_reg  <= prod[15:8];
        end
        if (cmd.clamp)
        begin
            d_reg      <= (DW'(d_raw_reg) > DW'(lm1)) ? lm1 : LW'(d_raw_reg);
            d_zero_reg <= (d_raw_reg == 22'd0);
        end
        if (cmd.rd1)
        begin
            r1_reg <= r1[AW-1:0];
        end
        if (cmd.rd2)
        begin
            s1_reg <= $signed(ram_rdata);
        end
        if (cmd.mix)
        begin
            y_reg <= acc_sh[SB-1:0];
        end
        if (cmd.fb)
        begin
            fb_reg <= fbp_sh[SB:0];
        end
        if (cmd.finish)
        begin
            out_data_reg <= d_zero_reg ? x_reg : y_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign stat.clear_last = (clear_cnt_reg == AW'(LINE_DEPTH - 1));
    assign stat.d_zero     = d_zero_reg;
    assign stat.out_busy   = out_valid_reg & !out_ready;

`ifndef SYNTHESIS
    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("ring written and read in the same cycle");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd1 |-> (({1'b0, wpos_reg} < len_reg) && (d_reg < len_reg)))
        else $error("write position or delay outside the active line");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished result not presented");
`endif

endmodule

[rtl/feedback_fractional_delay_line.sv]
`timescale 1ns / 1ps
// steps: load, scale, clamp, two tap reads, mix, feedback, finish; zero integer delay
//   skips the ring and passes the input on. One request at a time, the next taken once
//   the last has finished: two taps read in turn through the single ring read port, the
//   scale, interpolate and feedback multiplies in turn, and a stalled output hold it back
// reset: ring cleared one entry a cycle, all LINE_DEPTH entries (65536 by default),
//   requests held off meanwhile; configuration writes are taken throughout
module feedback_fractional_delay_line #(
    parameter int LINE_DEPTH  = ffdl_pkg::LINE_DEPTH_DEF,
    parameter int SAMPLE_BITS = ffdl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [ffdl_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [ffdl_pkg::CFG_DATA_BITS-1:0]  wr_data,
    ffdl_req_if.sink                            request,
    ffdl_rsp_if.source                          response
);

    ffdl_pkg::ffdl_cmd_t  cmd;
    ffdl_pkg::ffdl_stat_t stat;
    logic                 in_ready;
    logic                 out_valid;
    logic signed [SAMPLE_BITS-1:0] out_data;

    // sequencer
    ffdl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic, ring and registers
    ffdl_dp #(
        .LINE_DEPTH  (LINE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .sample_in     (request.sample_in),
        .delay_ms      (request.delay_ms),
        .feedback_gain (request.feedback_gain),
        .out_ready     (response.ready),
        .out_valid     (out_valid),
        .out_data      (out_data),
        .cmd           (cmd),
        .stat          (stat)
    );

    assign request.ready       = in_ready;
    assign response.valid      = out_valid;
    assign response.sample_out = out_data;

endmodule
